/* hdl/assert_macros.svh */
// Assertion helpers included by the allocator RTL to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/fpa_pkg.sv */
`timescale 1ns / 1ps

package fpa_pkg;

    // Size of the managed page region.
    localparam int NUM_PAGES = 1024;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    // Counters that must also hold NUM_PAGES itself.
    localparam int CNT_W     = PAGE_W + 1;

    // Fixed field widths.
    localparam int CFG_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int INDEX_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int START_W   = 10;
    localparam int FREED_W   = 11;

    // Width used for range checks that mix page indexes and sizes.
    localparam int WIDE_W    = ((PAGE_W > SIZE_W) ? PAGE_W : SIZE_W) + 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_NOSPACE = 2'd1;
    localparam status_t STATUS_BADADDR = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

/* hdl/first_fit_page_allocator_unit.sv */
`timescale 1ns / 1ps

// First-fit page allocator. Each request word is either an allocate (op 0)
// carrying a page count or a free (op 1) naming the start page of an earlier
// allocation, and each request produces exactly one result word. The used-page
// map and the per-page run lengths live in two single-port-write, registered-
// read memories of NUM_PAGES entries. After reset the block first sweeps both
// memories to zero, one entry per cycle, and in_ready stays low until the sweep
// is done; first_page writes are taken during that sweep as always.
// The block handles one request at a time. An allocate is accepted, walks the
// map for a first fit and then marks the pages of the new run before its
// result is loaded into the output register; a request rejected by the range
// checks goes straight to the output register. A free reads the recorded run
// length, loads it and then releases the recorded pages.
// The map scan walks the used bits one page per cycle through the
// memory read port, and marking and releasing use the single write port one
// page per cycle. A finished result sits in an output register, so the next
// request is accepted while the previous result waits for out_ready. The
// first_page register may only be written while no request is in flight.
module first_fit_page_allocator_unit
    import fpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration: lowest page usable for allocations.
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // Request channel.
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [SIZE_W-1:0]   size_pages,
    input  logic [INDEX_W-1:0]  page_index,
    // Result channel.
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [START_W-1:0]  start_page,
    output logic [FREED_W-1:0]  freed_pages
);

`include "assert_macros.svh"

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;  // reset sweep of both memories
    localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a request word
    localparam logic [2:0] S_SCAN  = 3'd2;  // first-fit walk of the used map
    localparam logic [2:0] S_MARK  = 3'd3;  // setting used bits of the new run
    localparam logic [2:0] S_FRD   = 3'd4;  // reading the recorded run length
    localparam logic [2:0] S_FCNT  = 3'd5;  // loading the run length
    localparam logic [2:0] S_FCLR  = 3'd6;  // releasing the recorded pages
    localparam logic [2:0] S_DONE  = 3'd7;  // handing the result to the output

    localparam logic [CNT_W-1:0]  LAST_PAGE = CNT_W'(NUM_PAGES - 1);
    localparam logic [CNT_W-1:0]  PAGES_CNT = CNT_W'(NUM_PAGES);
    localparam logic [WIDE_W-1:0] PAGES_W   = WIDE_W'(NUM_PAGES);

    // Memories: one used bit and one recorded run length per page.
    logic                used_mem [NUM_PAGES];
    logic [SIZE_W-1:0]   run_mem  [NUM_PAGES];

    // Control registers.
    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [CFG_W-1:0]    first_page_reg, first_page_next;
    logic                chk_valid_reg, chk_valid_next;
    logic                out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [SIZE_W-1:0]   need_reg, need_next;
    logic [INDEX_W-1:0]  page_reg, page_next;
    logic [CNT_W-1:0]    iss_addr_reg, iss_addr_next;
    logic [CNT_W-1:0]    chk_addr_reg, chk_addr_next;
    logic [SIZE_W-1:0]   run_reg, run_next;
    logic [CNT_W-1:0]    start_reg, start_next;
    logic [CNT_W-1:0]    work_addr_reg, work_addr_next;
    logic [SIZE_W-1:0]   left_reg, left_next;
    logic [FREED_W-1:0]  released_reg, released_next;
    status_t             res_status_reg, res_status_next;
    logic [START_W-1:0]  res_start_reg, res_start_next;
    status_t             status_reg, status_next;
    logic [START_W-1:0]  start_page_reg, start_page_next;
    logic [FREED_W-1:0]  freed_pages_reg, freed_pages_next;

    // Memory read data, registered.
    logic                used_rd_reg;
    logic [SIZE_W-1:0]   run_rd_reg;

    // Memory port controls.
    logic                used_re;
    logic [PAGE_W-1:0]   used_raddr;
    logic                used_we;
    logic [PAGE_W-1:0]   used_waddr;
    logic                used_wdata;
    logic                run_re;
    logic [PAGE_W-1:0]   run_raddr;
    logic                run_we;
    logic [PAGE_W-1:0]   run_waddr;
    logic [SIZE_W-1:0]   run_wdata;

    // Request decode and range checks.
    logic                accept;
    logic [WIDE_W-1:0]   fp_wide;
    logic [WIDE_W-1:0]   size_wide;
    logic [WIDE_W-1:0]   idx_wide;
    logic                alloc_reject;
    logic                free_reject;

    // Scan step.
    logic [SIZE_W-1:0]   run_inc;
    logic [CNT_W-1:0]    run_start;
    logic                run_found;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign start_page  = start_page_reg;
    assign freed_pages = freed_pages_reg;

    assign fp_wide   = WIDE_W'(first_page_reg);
    assign size_wide = WIDE_W'(size_pages);
    assign idx_wide  = WIDE_W'(page_index);

    // An allocate fails at once when it asks for nothing, when the region
    // starts past its end, or when the request cannot fit above first_page.
    assign alloc_reject = (size_pages == '0) || (fp_wide >= PAGES_W) ||
                          (size_wide > (PAGES_W - fp_wide));
    assign free_reject  = (fp_wide >= PAGES_W) || (idx_wide < fp_wide) ||
                          (idx_wide >= PAGES_W);

    // A free page either starts a new candidate run or extends the current one.
    assign run_inc   = run_reg + SIZE_W'(1);
    assign run_start = (run_reg == '0) ? chk_addr_reg : start_reg;
    assign run_found = chk_valid_reg && !used_rd_reg && (run_inc == need_reg);

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        first_page_next  = cfg_we ? cfg_wdata : first_page_reg;
        chk_valid_next   = 1'b0;
        out_valid_next   = out_valid_reg && !out_ready;

        need_next        = need_reg;
        page_next        = page_reg;
        iss_addr_next    = iss_addr_reg;
        chk_addr_next    = chk_addr_reg;
        run_next         = run_reg;
        start_next       = start_reg;
        work_addr_next   = work_addr_reg;
        left_next        = left_reg;
        released_next    = released_reg;
        res_status_next  = res_status_reg;
        res_start_next   = res_start_reg;
        status_next      = status_reg;
        start_page_next  = start_page_reg;
        freed_pages_next = freed_pages_reg;

        used_re    = 1'b0;
        used_raddr = iss_addr_reg[PAGE_W-1:0];
        used_we    = 1'b0;
        used_waddr = work_addr_reg[PAGE_W-1:0];
        used_wdata = 1'b0;
        run_re     = 1'b0;
        run_raddr  = PAGE_W'(page_reg);
        run_we     = 1'b0;
        run_waddr  = work_addr_reg[PAGE_W-1:0];
        run_wdata  = '0;

        case (state_reg)
            S_CLEAR:
            begin
                used_we       = 1'b1;
                used_waddr    = clr_addr_reg[PAGE_W-1:0];
                run_we        = 1'b1;
                run_waddr     = clr_addr_reg[PAGE_W-1:0];
                clr_addr_next = clr_addr_reg + CNT_W'(1);
                if (clr_addr_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    need_next       = size_pages;
                    page_next       = page_index;
                    released_next   = '0;
                    res_start_next  = '0;
                    run_next        = '0;
                    iss_addr_next   = CNT_W'(first_page_reg);
                    if (op == OP_ALLOC)
                    begin
                        if (alloc_reject)
                        begin
                            res_status_next = STATUS_NOSPACE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (free_reject)
                        begin
                            res_status_next = STATUS_BADADDR;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next map read while the previous one is checked.
                if (iss_addr_reg < PAGES_CNT)
                begin
                    used_re        = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_addr_next  = iss_addr_reg;
                    iss_addr_next  = iss_addr_reg + CNT_W'(1);
                end
                if (chk_valid_reg)
                begin
                    if (used_rd_reg)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next   = run_inc;
                        start_next = run_start;
                    end
                    if (run_found)
                    begin
                        // Record the run length now; the write port is free.
                        run_we          = 1'b1;
                        run_waddr       = run_start[PAGE_W-1:0];
                        run_wdata       = need_reg;
                        work_addr_next  = run_start;
                        left_next       = need_reg;
                        res_start_next  = START_W'(run_start);
                        chk_valid_next  = 1'b0;
                        state_next      = S_MARK;
                    end
                    else if (chk_addr_reg == LAST_PAGE)
                    begin
                        res_status_next = STATUS_NOSPACE;
                        chk_valid_next  = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_MARK:
            begin
                used_we        = 1'b1;
                used_wdata     = 1'b1;
                work_addr_next = work_addr_reg + CNT_W'(1);
                left_next      = left_reg - SIZE_W'(1);
                if (left_reg == SIZE_W'(1))
                begin
                    res_status_next = STATUS_OK;
                    state_next      = S_DONE;
                end
            end

            S_FRD:
            begin
                run_re         = 1'b1;
                work_addr_next = CNT_W'(page_reg);
                state_next     = S_FCNT;
            end

            S_FCNT:
            begin
                left_next  = run_rd_reg;
                state_next = S_FCLR;
            end

            S_FCLR:
            begin
                // Pages past the end of the region are never released.
                if ((left_reg == '0) || (work_addr_reg >= PAGES_CNT))
                begin
                    res_status_next = STATUS_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    used_we        = 1'b1;
                    run_we         = 1'b1;
                    work_addr_next = work_addr_reg + CNT_W'(1);
                    left_next      = left_reg - SIZE_W'(1);
                    released_next  = released_reg + FREED_W'(1);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    start_page_next  = res_start_reg;
                    freed_pages_next = released_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            first_page_reg <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            first_page_reg <= first_page_next;
            chk_valid_reg  <= chk_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg        <= need_next;
        page_reg        <= page_next;
        iss_addr_reg    <= iss_addr_next;
        chk_addr_reg    <= chk_addr_next;
        run_reg         <= run_next;
        start_reg       <= start_next;
        work_addr_reg   <= work_addr_next;
        left_reg        <= left_next;
        released_reg    <= released_next;
        res_status_reg  <= res_status_next;
        res_start_reg   <= res_start_next;
        status_reg      <= status_next;
        start_page_reg  <= start_page_next;
        freed_pages_reg <= freed_pages_next;
    end

    // Used-page map. Reads and writes of one request never touch the same
    // entry in overlapping cycles, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        if (used_re)
        begin
            used_rd_reg <= used_mem[used_raddr];
        end
    end

    // Run-length store.
    always_ff @(posedge clk)
    begin
        if (run_we)
        begin
            run_mem[run_waddr] <= run_wdata;
        end
        if (run_re)
        begin
            run_rd_reg <= run_mem[run_raddr];
        end
    end

    // Only one request is in flight: an accepted word closes the input.
    `ASSERT_NXT(a_one_in_flight, clk, rst_n, accept, !in_ready, "request accepted while busy")

    // Marking never starts or continues with nothing left to mark.
    `ASSERT_IMP(a_mark_nonempty, clk, rst_n, state_reg == S_MARK, left_reg != '0, "empty mark")

    // Only a successful free reports released pages, and never a start page.
    `ASSERT_IMP(a_freed_only_ok, clk, rst_n, out_valid && (freed_pages != '0),
        (status == STATUS_OK) && (start_page == '0), "freed pages on a failed result")

    // The scan never checks a page below the configured first page.
    `ASSERT_IMP(a_scan_floor, clk, rst_n, (state_reg == S_SCAN) && chk_valid_reg,
        WIDE_W'(chk_addr_reg) >= fp_wide, "scan below first page")

endmodule
